// ===== hw/rtl/dnsp_pkg.sv =====
// dnsp_pkg: shared types and constants for the dns message stream parser
// no dependencies

package dnsp_pkg;

   localparam int unsigned IndexWidth = 18;
   localparam int unsigned QueueDepth = 2;

   typedef enum logic [3:0] {
      KIND_ID        = 4'd0,
      KIND_FLAGS     = 4'd1,
      KIND_QDCOUNT   = 4'd2,
      KIND_ANCOUNT   = 4'd3,
      KIND_NSCOUNT   = 4'd4,
      KIND_ARCOUNT   = 4'd5,
      KIND_LABEL_LEN = 4'd6,
      KIND_LABEL_CHR = 4'd7,
      KIND_NAME_END  = 4'd8,
      KIND_POINTER   = 4'd9,
      KIND_TYPE      = 4'd10,
      KIND_CLASS     = 4'd11,
      KIND_TTL       = 4'd12,
      KIND_RDLENGTH  = 4'd13,
      KIND_RDATA     = 4'd14,
      KIND_EXTRA     = 4'd15
   } kind_type;

   typedef enum logic [1:0] {
      SEC_HEADER   = 2'd0,
      SEC_QUESTION = 2'd1,
      SEC_RECORD   = 2'd2,
      SEC_AFTER    = 2'd3
   } section_type;

   typedef enum logic [1:0] {
      STATUS_NORMAL    = 2'd0,
      STATUS_TRUNCATED = 2'd1,
      STATUS_TRAILING  = 2'd2
   } status_type;

   // one classified byte as it travels from front to back
   typedef struct packed {
      logic [7:0]            data_byte;
      logic                  last_byte;
      kind_type              kind;
      section_type           section;
      logic [IndexWidth-1:0] index;
      logic                  numeric;
      logic                  field_end;
      logic                  message_done;
   } token_type;

   typedef struct packed {
      logic [7:0]            byte_echo;
      kind_type              element_kind;
      section_type           section;
      logic [IndexWidth-1:0] item_index;
      logic                  field_done;
      logic [31:0]           field_value;
      logic                  message_done;
      status_type            status;
   } result_type;

endpackage

// ===== hw/rtl/dnsp_front.sv =====
// dnsp_front: walks the message layout and classifies each byte
// depends on dnsp_pkg

module dnsp_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [7:0]          in_byte,
   input  logic                in_last,
   output logic                tok_valid,
   input  logic                tok_ready,
   output dnsp_pkg::token_type tok
);
   import dnsp_pkg::*;

   kind_type              kind_ff, kind_in;
   section_type           sec_ff, sec_in;
   logic [1:0]            bif_ff, bif_in;
   logic [7:0]            hi_ff, hi_in;     // previous byte of a 16-bit field
   logic [15:0]           qleft_ff, qleft_in;
   logic [IndexWidth-1:0] rleft_ff, rleft_in;
   logic [IndexWidth-1:0] idx_ff, idx_in;
   logic [5:0]            lleft_ff, lleft_in;
   logic [15:0]           dleft_ff, dleft_in;
   logic [IndexWidth-1:0] rsum_ff, rsum_in;

   logic        take;
   logic [15:0] word;
   logic        fin;
   logic        fend;
   logic        numeric;
   kind_type    kind_out;
   section_type sec_out;
   logic [5:0]  lnext;
   logic [15:0] dnext;
   logic [15:0] qnext;
   logic [IndexWidth-1:0] rnext;

   assign in_ready = tok_ready;
   assign tok_valid = in_valid;
   assign take = in_valid && in_ready;
   assign word = {hi_ff, in_byte};
   assign lnext = lleft_ff - 6'd1;
   assign dnext = dleft_ff - 16'd1;
   assign qnext = qleft_ff - 16'd1;
   assign rnext = rleft_ff - IndexWidth'(1);

   always_comb begin
      kind_in  = kind_ff;
      sec_in   = sec_ff;
      bif_in   = bif_ff;
      hi_in    = in_byte;
      qleft_in = qleft_ff;
      rleft_in = rleft_ff;
      idx_in   = idx_ff;
      lleft_in = lleft_ff;
      dleft_in = dleft_ff;
      rsum_in  = rsum_ff;
      fin      = 1'b0;
      fend     = 1'b0;
      numeric  = 1'b0;
      kind_out = (sec_ff == SEC_AFTER) ? KIND_EXTRA : kind_ff;
      sec_out  = sec_ff;
      case (kind_out)
         KIND_ID, KIND_FLAGS, KIND_QDCOUNT, KIND_ANCOUNT, KIND_NSCOUNT,
         KIND_ARCOUNT, KIND_TYPE, KIND_CLASS, KIND_TTL, KIND_RDLENGTH: begin
            numeric = 1'b1;
            fend = (kind_out == KIND_TTL) ? (bif_ff == 2'd3) : (bif_ff == 2'd1);
            bif_in = fend ? 2'd0 : bif_ff + 2'd1;
         end
         default: ;
      endcase
      // record/question boundaries modeled in one place
      case (kind_out)
         KIND_ID, KIND_FLAGS, KIND_ANCOUNT, KIND_NSCOUNT, KIND_TYPE, KIND_TTL: begin
            if (fend) begin
               kind_in = kind_type'(kind_out + 4'd1);
               if (kind_out == KIND_ANCOUNT) rsum_in = IndexWidth'(word);
               if (kind_out == KIND_NSCOUNT) rsum_in = rsum_ff + IndexWidth'(word);
            end
         end
         KIND_QDCOUNT: begin
            if (fend) begin
               qleft_in = word;
               kind_in  = KIND_ANCOUNT;
            end
         end
         KIND_ARCOUNT: begin
            if (fend) begin
               idx_in = '0;
               rsum_in = rsum_ff + IndexWidth'(word);
               if (qleft_ff != 16'd0) begin
                  sec_in = SEC_QUESTION; kind_in = KIND_LABEL_LEN;
               end else if (rsum_ff + IndexWidth'(word) != '0) begin
                  rleft_in = rsum_ff + IndexWidth'(word);
                  sec_in = SEC_RECORD; kind_in = KIND_LABEL_LEN;
               end else begin
                  sec_in = SEC_AFTER; kind_in = KIND_EXTRA; fin = 1'b1;
               end
            end
         end
         KIND_LABEL_LEN: begin
            if (in_byte[7:6] != 2'b00) begin
               kind_out = KIND_POINTER; kind_in = KIND_POINTER;
            end else if (in_byte == 8'd0) begin
               kind_out = KIND_NAME_END; kind_in = KIND_TYPE;
            end else begin
               lleft_in = in_byte[5:0]; kind_in = KIND_LABEL_CHR;
            end
         end
         KIND_LABEL_CHR: begin
            lleft_in = lnext;
            if (lnext == 6'd0) kind_in = KIND_LABEL_LEN;
         end
         KIND_POINTER: kind_in = KIND_TYPE;
         KIND_CLASS: begin
            if (fend) begin
               if (sec_ff == SEC_QUESTION) begin
                  qleft_in = qnext;
                  idx_in = idx_ff + IndexWidth'(1);
                  if (qnext != 16'd0) kind_in = KIND_LABEL_LEN;
                  else begin
                     idx_in = '0;
                     rleft_in = rsum_ff;
                     if (rsum_ff != '0) begin
                        sec_in = SEC_RECORD; kind_in = KIND_LABEL_LEN;
                     end else begin
                        sec_in = SEC_AFTER; kind_in = KIND_EXTRA; fin = 1'b1;
                     end
                  end
               end else kind_in = KIND_TTL;
            end
         end
         KIND_RDLENGTH, KIND_RDATA: begin
            if (kind_out == KIND_RDLENGTH) begin
               dleft_in = word;
            end else begin
               dleft_in = dnext;
            end
            if ((kind_out == KIND_RDLENGTH && fend) || kind_out == KIND_RDATA) begin
               if ((kind_out == KIND_RDLENGTH ? word : dnext) == 16'd0) begin
                  rleft_in = rnext;
                  idx_in = idx_ff + IndexWidth'(1);
                  if (rnext != '0) kind_in = KIND_LABEL_LEN;
                  else begin
                     sec_in = SEC_AFTER; kind_in = KIND_EXTRA;
                     idx_in = '0; fin = 1'b1;
                  end
               end else kind_in = KIND_RDATA;
            end
         end
         default: begin
            kind_out = KIND_EXTRA; sec_out = SEC_AFTER;
            sec_in = SEC_AFTER; kind_in = KIND_EXTRA;
         end
      endcase
   end

   always_comb begin
      tok.data_byte     = in_byte;
      tok.last_byte     = in_last;
      tok.kind          = kind_out;
      tok.section       = sec_out;
      tok.index         = (sec_out == SEC_QUESTION || sec_out == SEC_RECORD) ? idx_ff : '0;
      tok.numeric       = numeric;
      tok.field_end     = fend;
      tok.message_done  = fin;
   end

   always_ff @(posedge clock) begin
      if (reset || (take && in_last)) begin
         kind_ff  <= KIND_ID;
         sec_ff   <= SEC_HEADER;
         bif_ff   <= '0;
         hi_ff    <= '0;
         qleft_ff <= '0;
         rleft_ff <= '0;
         idx_ff   <= '0;
         lleft_ff <= '0;
         dleft_ff <= '0;
         rsum_ff  <= '0;
      end else if (take) begin
         kind_ff  <= kind_in;
         sec_ff   <= sec_in;
         bif_ff   <= bif_in;
         hi_ff    <= hi_in;
         qleft_ff <= qleft_in;
         rleft_ff <= rleft_in;
         idx_ff   <= idx_in;
         lleft_ff <= lleft_in;
         dleft_ff <= dleft_in;
         rsum_ff  <= rsum_in;
      end
   end

`ifndef SYNTHESIS
   a_after_is_extra: assert property (@(posedge clock) disable iff (reset)
      sec_ff == SEC_AFTER |-> kind_ff == KIND_EXTRA)
      else $error("after section without extra kind");
   a_done_moves_after: assert property (@(posedge clock) disable iff (reset)
      take && fin && !in_last |=> sec_ff == SEC_AFTER)
      else $error("message done did not end message");
   a_bif_ttl_only: assert property (@(posedge clock) disable iff (reset)
      bif_ff > 2'd1 |-> kind_ff == KIND_TTL)
      else $error("wide byte count outside ttl");
`endif
endmodule

// ===== hw/rtl/dnsp_queue.sv =====
// dnsp_queue: short token queue between front and back
// depends on dnsp_pkg

module dnsp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_valid,
   output logic                wr_ready,
   input  dnsp_pkg::token_type wr_tok,
   output logic                rd_valid,
   input  logic                rd_ready,
   output dnsp_pkg::token_type rd_tok
);
   import dnsp_pkg::*;

   localparam int unsigned PtrWidth = $clog2(QueueDepth);

   token_type            mem_ff [QueueDepth];
   logic [PtrWidth-1:0]  wptr_ff, rptr_ff;
   logic [PtrWidth:0]    count_ff;
   logic                 push, pop;

   assign wr_ready = count_ff != (PtrWidth+1)'(QueueDepth);
   assign rd_valid = count_ff != '0;
   assign rd_tok   = mem_ff[rptr_ff];
   assign push = wr_valid && wr_ready;
   assign pop  = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wptr_ff] <= wr_tok;
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (push) wptr_ff <= wptr_ff + PtrWidth'(1);
         if (pop)  rptr_ff <= rptr_ff + PtrWidth'(1);
         count_ff <= count_ff + (PtrWidth+1)'(push) - (PtrWidth+1)'(pop);
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (PtrWidth+1)'(QueueDepth))
      else $error("queue overflow");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + (PtrWidth+1)'(1))
      else $error("queue count slip");
   a_pop_track: assert property (@(posedge clock) disable iff (reset)
      pop && !push |=> count_ff == $past(count_ff) - (PtrWidth+1)'(1))
      else $error("queue count slip on pop");
`endif
endmodule

// ===== hw/rtl/dnsp_back.sv =====
// dnsp_back: assembles numeric fields and forms each result
// depends on dnsp_pkg

module dnsp_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 tok_valid,
   output logic                 tok_ready,
   input  dnsp_pkg::token_type  tok,
   output logic                 res_valid,
   input  logic                 res_ready,
   output dnsp_pkg::result_type res
);
   import dnsp_pkg::*;

   logic [23:0] acc_ff, acc_in;     // bytes of the field seen so far
   logic        valid_ff;
   result_type  res_ff, res_in;
   logic        take;
   logic [31:0] full;

   assign tok_ready = !valid_ff || res_ready;
   assign take = tok_valid && tok_ready;
   assign res_valid = valid_ff;
   assign res = res_ff;
   assign full = {acc_ff, tok.data_byte};

   always_comb begin
      acc_in = acc_ff;
      if (tok.numeric) acc_in = tok.field_end ? '0 : full[23:0];
      res_in.byte_echo    = tok.data_byte;
      res_in.element_kind = tok.kind;
      res_in.section      = tok.section;
      res_in.item_index   = tok.index;
      res_in.field_done   = tok.field_end;
      res_in.field_value  = tok.field_end ? full : '0;
      res_in.message_done = tok.message_done;
      if (tok.section == SEC_AFTER) res_in.status = STATUS_TRAILING;
      else if (tok.last_byte && !tok.message_done) res_in.status = STATUS_TRUNCATED;
      else res_in.status = STATUS_NORMAL;
   end

   always_ff @(posedge clock) begin
      if (take) res_ff <= res_in;
      if (reset) begin
         valid_ff <= 1'b0;
         acc_ff   <= '0;
      end else begin
         if (take) valid_ff <= 1'b1;
         else if (res_ready) valid_ff <= 1'b0;
         if (take) acc_ff <= tok.last_byte ? '0 : acc_in;
      end
   end

`ifndef SYNTHESIS
   a_value_only_done: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !res_ff.field_done |-> res_ff.field_value == '0)
      else $error("field value without done");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !res_ready |=> valid_ff && $stable(res_ff))
      else $error("result lost under stall");
   a_trailing: assert property (@(posedge clock) disable iff (reset)
      valid_ff && res_ff.section == SEC_AFTER |-> res_ff.status == STATUS_TRAILING)
      else $error("trailing status missing");
`endif
endmodule

// ===== hw/rtl/dns_message_stream_parser.sv =====
// dns_message_stream_parser: top level, front classifier, queue, back formatter
// path: an accepted byte is written to a queue slot, then held in the back result register until taken
// throughput: one byte per cycle while the queue has room, set by the front state update per byte
// reset: synchronous active high; clears parse state, queue pointers and the output valid flag
// a byte marked last returns the parse to the header for the next message
// depends on dnsp_pkg, dnsp_front, dnsp_queue, dnsp_back

module dns_message_stream_parser (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [7:0]                        req_data_byte,
   input  logic                              req_last_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [7:0]                        rsp_byte_echo,
   output logic [3:0]                        rsp_element_kind,
   output logic [1:0]                        rsp_section,
   output logic [dnsp_pkg::IndexWidth-1:0]   rsp_item_index,
   output logic                              rsp_field_done,
   output logic [31:0]                       rsp_field_value,
   output logic                              rsp_message_done,
   output logic [1:0]                        rsp_status
);
   import dnsp_pkg::*;

   // front to queue transaction
   logic       f_valid, f_ready;
   token_type  f_tok;
   // queue to back transaction
   logic       q_valid, q_ready;
   token_type  q_tok;
   result_type res;

   // front: one state update per byte, the queue absorbs output stalls
   dnsp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_byte   (req_data_byte),
      .in_last   (req_last_byte),
      .tok_valid (f_valid),
      .tok_ready (f_ready),
      .tok       (f_tok)
   );

   dnsp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (f_valid),
      .wr_ready (f_ready),
      .wr_tok   (f_tok),
      .rd_valid (q_valid),
      .rd_ready (q_ready),
      .rd_tok   (q_tok)
   );

   // back: field assembly and registered result
   dnsp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .tok_valid (q_valid),
      .tok_ready (q_ready),
      .tok       (q_tok),
      .res_valid (rsp_valid),
      .res_ready (rsp_ready),
      .res       (res)
   );

   assign rsp_byte_echo    = res.byte_echo;
   assign rsp_element_kind = res.element_kind;
   assign rsp_section      = res.section;
   assign rsp_item_index   = res.item_index;
   assign rsp_field_done   = res.field_done;
   assign rsp_field_value  = res.field_value;
   assign rsp_message_done = res.message_done;
   assign rsp_status       = res.status;

`ifndef SYNTHESIS
   a_ready_when_room: assert property (@(posedge clock) disable iff (reset)
      req_ready == f_ready)
      else $error("front ready not tied to queue room");
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      !q_valid && !$past(q_valid) && !$past(rsp_valid) |-> !rsp_valid)
      else $error("result without transaction");
   a_done_normal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_message_done |-> rsp_status == STATUS_NORMAL)
      else $error("done with bad status");
`endif
endmodule
